FILE: rtl/core/mmutw_pkg.sv
// ----------------------------------------------------------------------------
// mmutw_pkg
// Shared types and codes for the two-level MMU table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package mmutw_pkg;

  // Operation carried by an input word
  localparam logic OP_REQUEST    = 1'b0;
  localparam logic OP_DESCRIPTOR = 1'b1;

  // Kind of a result word
  localparam logic RK_READ = 1'b0;
  localparam logic RK_DONE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOM_CTRL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_ROM = 2'd2;

  // Descriptor type field, bits 1..0
  localparam logic [1:0] L1_FAULT   = 2'd0;
  localparam logic [1:0] L1_PAGE    = 2'd1;
  localparam logic [1:0] L1_SECTION = 2'd2;
  localparam logic [1:0] L2_LARGE   = 2'd1;
  localparam logic [1:0] L2_SMALL   = 2'd2;

  // Domain access codes
  localparam logic [1:0] DA_NONE     = 2'd0;
  localparam logic [1:0] DA_CLIENT   = 2'd1;
  localparam logic [1:0] DA_RESERVED = 2'd2;
  localparam logic [1:0] DA_MANAGER  = 2'd3;

  // Access permission codes
  localparam logic [1:0] AP_ROM_SYS = 2'd0;
  localparam logic [1:0] AP_PRIV    = 2'd1;
  localparam logic [1:0] AP_USER_RO = 2'd2;

  // S/R bit settings for AP zero
  localparam logic [1:0] SR_SYSTEM = 2'd1;
  localparam logic [1:0] SR_ROM    = 2'd2;

  // Fault codes, low nibble of the fault status
  localparam logic [3:0] FC_TRANS_SECTION  = 4'h5;
  localparam logic [3:0] FC_TRANS_PAGE     = 4'h7;
  localparam logic [3:0] FC_DOMAIN_SECTION = 4'h9;
  localparam logic [3:0] FC_DOMAIN_PAGE    = 4'hb;
  localparam logic [3:0] FC_PERM_SECTION   = 4'hd;
  localparam logic [3:0] FC_PERM_PAGE      = 4'hf;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] virtual_address;
    logic        wr_access;
    logic        is_prefetch;
    logic        privileged;
    logic [31:0] descriptor_data;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] read_address;
    logic [31:0] physical_address;
    logic        fault;
    logic [7:0]  abort_status;
    logic [31:0] abort_addr;
  } out_word_t;

endpackage

`default_nettype wire

FILE: rtl/core/mmutw_if.sv
// ----------------------------------------------------------------------------
// mmutw_if
// Valid/ready channels of the table walker: input, result and config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmutw_in_if;
  logic                valid;
  logic                ready;
  mmutw_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mmutw_out_if;
  logic                 valid;
  logic                 ready;
  mmutw_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mmutw_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mmutw_pkg::CFG_IDX_W-1:0]    index;
  logic [31:0]                        wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mmu_two_level_table_walk_top.sv
// ----------------------------------------------------------------------------
// mmu_two_level_table_walk_top
// Two-level page table walker: sections, large and small pages, domain and
// permission checks, fault status and fault address recording.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Word
//  -------  ---  -------------  ------------------------------------------
//  in_i     in   valid/ready    request or returning descriptor
//  out_o    out  valid/ready    descriptor read request or finished result
//  cfg_i    in   valid/ready    register write: table base, domains, S/R
//
//  Every input word is decoded and checked in the cycle it is accepted; its
//  result is registered and shows on out_o, one word per cycle while
//  out_o.ready is high. The output register plus a skid entry let
//  a new word in while a result still waits; in_i.ready drops only while
//  the skid entry is full. A descriptor arriving with no walk in progress
//  produces no result. Reset clears the walk state, the fault and
//  configuration registers and both result valid flags to zero.
//
`default_nettype none

module mmu_two_level_table_walk_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mmutw_in_if.sink         in_i,
  mmutw_out_if.source      out_o,
  mmutw_cfg_if.sink        cfg_i
);

  // Configuration registers
  logic [17:0] table_base_q;
  logic [31:0] dom_ctrl_q;
  logic [1:0]  system_rom_q;

  // Walk state
  mmutw_pkg::phase_e phase_q, phase_d;
  logic [31:0] vaddr_q, vaddr_d;
  logic        write_q, write_d;
  logic        prefetch_q, prefetch_d;
  logic        priv_q, priv_d;
  logic [31:0] first_desc_q, first_desc_d;
  logic [7:0]  fsr_q, fsr_d;
  logic [31:0] far_q, far_d;

  // Result register and skid entry
  mmutw_pkg::out_word_t out_q, skid_q, rsp;
  logic                 out_valid_q, skid_valid_q;
  logic                 has_result;

  logic                 in_accept, out_take;
  mmutw_pkg::in_word_t  iw;

  // Decode helpers
  logic [31:0] desc;
  logic [3:0]  dom;
  logic [1:0]  dom_bits;
  logic [1:0]  ap;
  logic        perm_bad;
  logic [31:0] page_paddr;

  function automatic logic perm_denied(input logic [1:0] ap_bits, input logic [1:0] sr,
                                       input logic wr, input logic pr);
    logic res;
    res = 1'b0;
    case (ap_bits)
      mmutw_pkg::AP_ROM_SYS: begin
        if (sr == mmutw_pkg::SR_SYSTEM) begin
          res = !pr || wr;
        end else if (sr == mmutw_pkg::SR_ROM) begin
          res = wr;
        end else begin
          res = 1'b1;
        end
      end
      mmutw_pkg::AP_PRIV:    res = !pr;
      mmutw_pkg::AP_USER_RO: res = !pr && wr;
      default:               res = 1'b0;
    endcase
    return res;
  endfunction

  assign iw        = in_i.data;
  assign desc      = iw.descriptor_data;
  assign in_i.ready = !skid_valid_q;
  assign in_accept = in_i.valid && in_i.ready;
  assign out_take  = out_valid_q && out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign cfg_i.ready = 1'b1;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_q <= '0;
      dom_ctrl_q   <= '0;
      system_rom_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mmutw_pkg::CFG_TABLE_BASE: table_base_q <= cfg_i.wdata[17:0];
        mmutw_pkg::CFG_DOM_CTRL:   dom_ctrl_q   <= cfg_i.wdata;
        mmutw_pkg::CFG_SYSTEM_ROM: system_rom_q <= cfg_i.wdata[1:0];
        default: ;
      endcase
    end
  end

  // Domain comes from the live descriptor on the first level, else the saved one
  assign dom      = (phase_q == mmutw_pkg::PH_FIRST) ? desc[8:5] : first_desc_q[8:5];
  assign dom_bits = dom_ctrl_q[{dom, 1'b0} +: 2];

  // AP field: section AP at 11..10; page subpage AP selected by vaddr bits
  always_comb begin
    logic [1:0] sub;
    sub = (desc[1:0] == mmutw_pkg::L2_LARGE) ? vaddr_q[15:14] : vaddr_q[11:10];
    if (phase_q == mmutw_pkg::PH_FIRST) begin
      ap = desc[11:10];
    end else begin
      ap = desc[{1'b0, sub, 1'b0} + 4'd4 +: 2];
    end
    page_paddr = (desc[1:0] == mmutw_pkg::L2_LARGE) ? {desc[31:16], vaddr_q[15:0]}
                                                     : {desc[31:12], vaddr_q[11:0]};
  end

  assign perm_bad = perm_denied(ap, system_rom_q, write_q, priv_q);

  // Next state of the walk
  always_comb begin
    phase_d      = phase_q;
    vaddr_d      = vaddr_q;
    write_d      = write_q;
    prefetch_d   = prefetch_q;
    priv_d       = priv_q;
    first_desc_d = first_desc_q;
    if (in_accept) begin
      if (iw.operation == mmutw_pkg::OP_REQUEST) begin
        // a request always restarts, abandoning any walk in flight
        phase_d    = mmutw_pkg::PH_FIRST;
        vaddr_d    = iw.virtual_address;
        write_d    = iw.wr_access;
        prefetch_d = iw.is_prefetch;
        priv_d     = iw.privileged;
      end else begin
        unique case (phase_q)
          mmutw_pkg::PH_FIRST: begin
            first_desc_d = desc;
            phase_d = (desc[1:0] == mmutw_pkg::L1_PAGE) ? mmutw_pkg::PH_SECOND
                                                        : mmutw_pkg::PH_IDLE;
          end
          mmutw_pkg::PH_SECOND: phase_d = mmutw_pkg::PH_IDLE;
          default: ;
        endcase
      end
    end
  end

  // Result word and fault register updates
  always_comb begin
    logic       flt;
    logic [3:0] code;
    flt        = 1'b0;
    code       = mmutw_pkg::FC_TRANS_SECTION;
    has_result = 1'b0;
    fsr_d      = fsr_q;
    far_d      = far_q;
    rsp        = '0;
    rsp.result_kind = mmutw_pkg::RK_DONE;
    if (in_accept) begin
      if (iw.operation == mmutw_pkg::OP_REQUEST) begin
        has_result       = 1'b1;
        rsp.result_kind  = mmutw_pkg::RK_READ;
        rsp.read_address = {table_base_q, iw.virtual_address[31:20], 2'b00};
      end else if (phase_q == mmutw_pkg::PH_FIRST) begin
        has_result = 1'b1;
        case (desc[1:0])
          mmutw_pkg::L1_PAGE: begin
            rsp.result_kind  = mmutw_pkg::RK_READ;
            rsp.read_address = {desc[31:10], vaddr_q[19:12], 2'b00};
          end
          mmutw_pkg::L1_SECTION: begin
            if (dom_bits == mmutw_pkg::DA_NONE || dom_bits == mmutw_pkg::DA_RESERVED) begin
              flt  = 1'b1;
              code = mmutw_pkg::FC_DOMAIN_SECTION;
            end else if (dom_bits == mmutw_pkg::DA_CLIENT && perm_bad) begin
              flt  = 1'b1;
              code = mmutw_pkg::FC_PERM_SECTION;
            end else begin
              rsp.physical_address = {desc[31:20], vaddr_q[19:0]};
            end
          end
          default: begin
            // type 0 and the reserved type 3 both abort as section translation
            flt  = 1'b1;
            code = mmutw_pkg::FC_TRANS_SECTION;
          end
        endcase
      end else if (phase_q == mmutw_pkg::PH_SECOND) begin
        has_result = 1'b1;
        if (desc[1:0] != mmutw_pkg::L2_LARGE && desc[1:0] != mmutw_pkg::L2_SMALL) begin
          flt  = 1'b1;
          code = mmutw_pkg::FC_TRANS_PAGE;
        end else if (dom_bits == mmutw_pkg::DA_NONE ||
                     dom_bits == mmutw_pkg::DA_RESERVED) begin
          flt  = 1'b1;
          code = mmutw_pkg::FC_DOMAIN_PAGE;
        end else if (dom_bits == mmutw_pkg::DA_CLIENT && perm_bad) begin
          flt  = 1'b1;
          code = mmutw_pkg::FC_PERM_PAGE;
        end else begin
          rsp.physical_address = page_paddr;
        end
      end
    end
    rsp.fault = flt;
    // record the fault only for data accesses
    if (flt && !prefetch_q) begin
      fsr_d = {dom, code};
      far_d = vaddr_q;
    end
    rsp.abort_status = fsr_d;
    rsp.abort_addr   = far_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= mmutw_pkg::PH_IDLE;
      vaddr_q      <= '0;
      write_q      <= 1'b0;
      prefetch_q   <= 1'b0;
      priv_q       <= 1'b0;
      first_desc_q <= '0;
      fsr_q        <= '0;
      far_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      vaddr_q      <= vaddr_d;
      write_q      <= write_d;
      prefetch_q   <= prefetch_d;
      priv_q       <= priv_d;
      first_desc_q <= first_desc_d;
      fsr_q        <= fsr_d;
      far_q        <= far_d;
    end
  end

  // Output register and skid entry occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      // advance: a new result fills the output register, or the skid entry
      // while the output register is held; drain the skid entry on a take
      if (has_result) begin
        out_valid_q <= 1'b1;
      end else if (out_take && !skid_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if (out_take && skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (has_result && out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end else if (has_result) begin
      if (!out_valid_q || out_take) begin
        out_q <= rsp;
      end else begin
        skid_q <= rsp;
      end
    end
  end

  // Skid entry is only ever used behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // Second level is reached only through a page table descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == mmutw_pkg::PH_SECOND) |-> (first_desc_q[1:0] == mmutw_pkg::L1_PAGE))
    else $error("second-level walk without a page table descriptor");

  // A request always starts a first-level lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && iw.operation == mmutw_pkg::OP_REQUEST) |=> (phase_q == mmutw_pkg::PH_FIRST))
    else $error("request did not start a first-level lookup");

  // An aborted translation never carries a physical address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fault) |->
      (out_q.physical_address == '0 && out_q.result_kind == mmutw_pkg::RK_DONE))
    else $error("fault result carries an address or wrong kind");

endmodule

`default_nettype wire

FILE: dv/tb_mmu_two_level_table_walk_top.sv
// ----------------------------------------------------------------------------
// tb_mmu_two_level_table_walk_top
// Self-checking bench for the two-level table walker. Requests and returning
// descriptors go in through in_i, each accepted word is run through a
// bit-true walker model, and every word on out_o is checked field by field
// against the oldest prediction. Register settings change between phases.
// ----------------------------------------------------------------------------

module tb_mmu_two_level_table_walk_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mmutw_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0] DESC_TYPE3    = 2'd3;  // L1 type 3, also an invalid L2 type
  localparam logic [1:0] L2_FAULT      = 2'd0;
  localparam logic [1:0] AP_FULL       = 2'd3;
  localparam logic [1:0] SR_BOTH_CLEAR = 2'b00;
  localparam logic [1:0] SR_BOTH_SET   = 2'b11;

  // Domain numbers used by the directed walks; the directed domain control
  // pattern 0xE4E4E4E4 gives domain d the access code d for d = 0..3
  localparam logic [3:0] DOM_NONE   = 4'd0;
  localparam logic [3:0] DOM_CLIENT = 4'd1;
  localparam logic [3:0] DOM_RSVD   = 4'd2;
  localparam logic [3:0] DOM_MGR    = 4'd3;

  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 240;
  localparam int LONG_HOLD       = 400;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_LIMIT     = 10000;
  localparam int TIMEOUT_NS      = 20_000_000;

  // --------------------------------------------------------------------------
  // Walker model and result store
  // --------------------------------------------------------------------------
  class walk_scoreboard;
    logic [17:0] table_base;
    logic [31:0] dom_ctrl;
    logic [1:0]  sr_bits;
    phase_e      walk_state;
    logic [31:0] vaddr;
    logic        wr, pf, priv;
    logic [31:0] first_desc;
    logic [7:0]  fsr;
    logic [31:0] far;
    out_word_t   expected_q[$];
    int          mismatches, read_count, done_count, fault_count;

    function new();
      table_base    = '0;
      dom_ctrl      = '0;
      sr_bits       = '0;
      walk_state    = PH_IDLE;
      vaddr         = '0;
      wr            = 1'b0;
      pf            = 1'b0;
      priv          = 1'b0;
      first_desc    = '0;
      fsr           = '0;
      far           = '0;
      mismatches    = 0;
      read_count    = 0;
      done_count    = 0;
      fault_count   = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        CFG_TABLE_BASE: table_base = value[17:0];
        CFG_DOM_CTRL:   dom_ctrl   = value;
        CFG_SYSTEM_ROM: sr_bits    = value[1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Client permission check of the saved access against one AP field
    function bit denied(logic [1:0] ap);
      case (ap)
        AP_ROM_SYS: begin
          case (sr_bits)
            SR_SYSTEM: return !priv || wr;
            SR_ROM:    return wr;
            default:   return 1'b1;
          endcase
        end
        AP_PRIV:    return !priv;
        AP_USER_RO: return !priv && wr;
        default:    return 1'b0;
      endcase
    endfunction

    // Prefetch aborts leave the fault registers alone
    function out_word_t aborted(logic [3:0] dom, logic [3:0] code);
      out_word_t r;
      if (!pf) begin
        far = vaddr;
        fsr = {dom, code};
      end
      walk_state    = PH_IDLE;
      r             = '0;
      r.result_kind = RK_DONE;
      r.fault       = 1'b1;
      return r;
    endfunction

    function out_word_t translated(logic [31:0] paddr);
      out_word_t r;
      walk_state         = PH_IDLE;
      r                  = '0;
      r.result_kind      = RK_DONE;
      r.physical_address = paddr;
      return r;
    endfunction

    function void note_input(in_word_t w);
      logic [3:0]  dom;
      logic [1:0]  da;
      logic [2:0]  ap_pos;
      logic [31:0] desc;
      logic [31:0] paddr;
      out_word_t   r;
      r    = '0;
      desc = w.descriptor_data;
      if (w.operation == OP_REQUEST) begin
        // A request always restarts the walk, abandoning any open one
        vaddr           = w.virtual_address;
        wr              = w.wr_access;
        pf              = w.is_prefetch;
        priv            = w.privileged;
        walk_state      = PH_FIRST;
        r.result_kind   = RK_READ;
        r.read_address  = {table_base, vaddr[31:20], 2'b00};
      end else if (walk_state == PH_FIRST) begin
        first_desc = desc;
        dom        = desc[8:5];
        da         = dom_ctrl[{dom, 1'b0} +: 2];
        case (desc[1:0])
          L1_PAGE: begin
            walk_state     = PH_SECOND;
            r.result_kind  = RK_READ;
            r.read_address = {desc[31:10], vaddr[19:12], 2'b00};
          end
          L1_SECTION: begin
            if (da == DA_NONE || da == DA_RESERVED)
              r = aborted(dom, FC_DOMAIN_SECTION);
            else if (da == DA_CLIENT && denied(desc[11:10]))
              r = aborted(dom, FC_PERM_SECTION);
            else
              r = translated({desc[31:20], vaddr[19:0]});
          end
          default: r = aborted(dom, FC_TRANS_SECTION);
        endcase
      end else if (walk_state == PH_SECOND) begin
        dom = first_desc[8:5];
        da  = dom_ctrl[{dom, 1'b0} +: 2];
        if (desc[1:0] != L2_LARGE && desc[1:0] != L2_SMALL) begin
          r = aborted(dom, FC_TRANS_PAGE);
        end else begin
          if (desc[1:0] == L2_LARGE) begin
            ap_pos = {vaddr[15:14], 1'b0};
            paddr  = {desc[31:16], vaddr[15:0]};
          end else begin
            ap_pos = {vaddr[11:10], 1'b0};
            paddr  = {desc[31:12], vaddr[11:0]};
          end
          if (da == DA_NONE || da == DA_RESERVED)
            r = aborted(dom, FC_DOMAIN_PAGE);
          else if (da == DA_CLIENT && denied(desc[4 + ap_pos +: 2]))
            r = aborted(dom, FC_PERM_PAGE);
          else
            r = translated(paddr);
        end
      end else begin
        return;  // descriptor with no walk open: dropped
      end
      r.abort_status = fsr;
      r.abort_addr   = far;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        // go quiet after the first hundred, keep counting
        if (mismatches < 100)
          $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        $error("result word %h arrived with nothing expected", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("read_address", want.read_address, got.read_address);
      compare_field("physical_address", want.physical_address, got.physical_address);
      compare_field("fault", want.fault, got.fault);
      compare_field("abort_status", want.abort_status, got.abort_status);
      compare_field("abort_addr", want.abort_addr, got.abort_addr);
      if (want.result_kind == RK_READ) read_count++;
      else if (want.fault)             fault_count++;
      else                             done_count++;
    endfunction

    function void report_leftovers();
      if (expected_q.size() != 0) begin
        $error("%0d expected result words never arrived", expected_q.size());
        mismatches += expected_q.size();
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  mmutw_in_if  in_bus();
  mmutw_out_if out_bus();
  mmutw_cfg_if cfg_bus();

  walk_scoreboard walk_sb = new();

  bit burst_mode;         // no gaps and no random stalls while set
  bit stall_stretch_req;  // ask the receiver for one long hold-off
  int words_sent;

  mmu_two_level_table_walk_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Sample every handshake at the edge that completes it. Values seen here
  // are the ones from before the edge, so the order of processes inside a
  // time step does not matter. Result first: a word accepted at this edge
  // can only show up on out_o at a later edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) walk_sb.check_result(out_bus.data);
      if (cfg_bus.valid && cfg_bus.ready) walk_sb.write_register(cfg_bus.index, cfg_bus.wdata);
      if (in_bus.valid && in_bus.ready)   walk_sb.note_input(in_bus.data);
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // --------------------------------------------------------------------------
  // Word builders: every field random, then the fields that matter forced
  // --------------------------------------------------------------------------
  function automatic in_word_t random_word();
    in_word_t w;
    w.operation       = 1'($urandom);
    w.virtual_address = $urandom;
    w.wr_access       = 1'($urandom);
    w.is_prefetch     = 1'($urandom);
    w.privileged      = 1'($urandom);
    w.descriptor_data = $urandom;
    return w;
  endfunction

  function automatic in_word_t make_req(logic [31:0] va, logic wr, logic pf, logic priv);
    in_word_t w;
    w                 = random_word();
    w.operation       = OP_REQUEST;
    w.virtual_address = va;
    w.wr_access       = wr;
    w.is_prefetch     = pf;
    w.privileged      = priv;
    return w;
  endfunction

  function automatic in_word_t desc_word(logic [31:0] d);
    in_word_t w;
    w                 = random_word();
    w.operation       = OP_DESCRIPTOR;
    w.descriptor_data = d;
    return w;
  endfunction

  function automatic logic [31:0] make_l1(logic [1:0] kind, logic [3:0] dom, logic [1:0] ap);
    logic [31:0] d;
    d        = $urandom;
    d[1:0]   = kind;
    d[8:5]   = dom;
    d[11:10] = ap;
    return d;
  endfunction

  // Same AP in all four subpage fields, so the subpage index does not matter
  function automatic logic [31:0] make_l2(logic [1:0] kind, logic [1:0] ap);
    logic [31:0] d;
    d       = $urandom;
    d[1:0]  = kind;
    d[11:4] = {4{ap}};
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one word and hold it until accepted; maybe idle afterwards
  task automatic send_word(input in_word_t w);
    in_bus.valid <= 1'b1;
    in_bus.data  <= w;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    words_sent++;
    if (!burst_mode && $urandom_range(0, 2) == 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
  endtask

  // One walk: request, first-level word and, for a page, the second one
  task automatic do_walk(input in_word_t req, input logic [31:0] l1, input logic [31:0] l2);
    send_word(req);
    send_word(desc_word(l1));
    if (l1[1:0] == L1_PAGE) send_word(desc_word(l2));
  endtask

  // Write all three registers back to back; upper bits carry junk
  task automatic configure(input logic [17:0] base, input logic [31:0] domains,
                           input logic [1:0] sr);
    logic [31:0]          values[3];
    logic [CFG_IDX_W-1:0] regs[3];
    values       = '{$urandom, domains, $urandom};
    values[0][17:0] = base;
    values[2][1:0]  = sr;
    regs         = '{CFG_TABLE_BASE, CFG_DOM_CTRL, CFG_SYSTEM_ROM};
    for (int k = 0; k < 3; k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= regs[k];
      cfg_bus.wdata <= values[k];
      @(posedge clk_i);
      while (!cfg_bus.ready) @(posedge clk_i);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Drop valid, wait for every predicted word, then wait out the
  // SETTLE_CYCLES margin before returning
  task automatic settle();
    int waited;
    waited = 0;
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (walk_sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly complete walks with random content; the rest is truncated walks
  // (abandoned by the next request) and descriptors nobody asked for
  task automatic run_random(input int goal);
    int          counted;
    int          pick;
    bit          walk_open;
    logic [31:0] l1, l2;
    counted   = 0;
    walk_open = 1'b0;
    while (counted < goal) begin
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_word(desc_word($urandom));
        if (walk_open) counted++;
        walk_open = 1'b0;
      end else if (pick < 16) begin
        send_word(make_req($urandom, 1'($urandom), 1'($urandom), 1'($urandom)));
        counted++;
        walk_open = 1'b1;
        if (pick < 11) begin
          send_word(desc_word(make_l1(L1_PAGE, 4'($urandom), 2'($urandom))));
          counted++;
        end
      end else begin
        l1 = $urandom;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: l1[1:0] = L1_SECTION;
          4, 5, 6, 7: l1[1:0] = L1_PAGE;
          8:          l1[1:0] = L1_FAULT;
          default:    l1[1:0] = DESC_TYPE3;
        endcase
        l2 = $urandom;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: l2[1:0] = L2_LARGE;
          4, 5, 6, 7: l2[1:0] = L2_SMALL;
          8:          l2[1:0] = L2_FAULT;
          default:    l2[1:0] = DESC_TYPE3;
        endcase
        do_walk(make_req($urandom, 1'($urandom), 1'($urandom), 1'($urandom)), l1, l2);
        counted  += (l1[1:0] == L1_PAGE) ? 3 : 2;
        walk_open = 1'b0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, ready runs, and one long hold-off on request.
  // Each pass drives ready once and then advances at least one edge.
  // --------------------------------------------------------------------------
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (stall_stretch_req) begin
        // hold off long enough for the output and skid entries to fill,
        // so in_i.ready drops while the sender keeps offering words
        stall_stretch_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.data   <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.wdata <= '0;
    burst_mode        = 1'b0;
    stall_stretch_req = 1'b0;
    words_sent        = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walks: top table base, one domain of each access code
    configure(18'h3ffff, 32'he4e4e4e4, SR_SYSTEM);
    // all-ones address, first-level fault word
    do_walk(make_req(32'hffffffff, 1'b1, 1'b0, 1'b1), make_l1(L1_FAULT, 4'hf, AP_PRIV), '0);
    // first-level type 3 aborts like a missing section
    do_walk(make_req($urandom, 1'b0, 1'b0, 1'b0), make_l1(DESC_TYPE3, DOM_CLIENT, AP_FULL), '0);
    // all-zero address, section in the reserved domain
    do_walk(make_req(32'h0, 1'b0, 1'b0, 1'b1), make_l1(L1_SECTION, DOM_RSVD, AP_FULL), '0);
    // manager skips the permission check even for a user write to AP 0
    do_walk(make_req($urandom, 1'b1, 1'b0, 1'b0), make_l1(L1_SECTION, DOM_MGR, AP_ROM_SYS), '0);
    // client, supervisor-only section, user read
    do_walk(make_req($urandom, 1'b0, 1'b0, 1'b0), make_l1(L1_SECTION, DOM_CLIENT, AP_PRIV), '0);
    // large page, user read-only, user write
    do_walk(make_req($urandom, 1'b1, 1'b0, 1'b0), make_l1(L1_PAGE, DOM_CLIENT, AP_FULL),
            make_l2(L2_LARGE, AP_USER_RO));
    // small page, full access
    do_walk(make_req($urandom, 1'b1, 1'b0, 1'b0), make_l1(L1_PAGE, DOM_CLIENT, AP_PRIV),
            make_l2(L2_SMALL, AP_FULL));
    // invalid second-level word
    do_walk(make_req($urandom, 1'b0, 1'b0, 1'b1), make_l1(L1_PAGE, DOM_MGR, AP_FULL),
            make_l2(L2_FAULT, AP_FULL));
    // prefetch abort must leave status and address untouched
    do_walk(make_req($urandom, 1'b0, 1'b1, 1'b1), make_l1(L1_SECTION, DOM_NONE, AP_FULL), '0);
    // abandon a walk halfway, then finish a fresh one on AP 0 with S set
    send_word(make_req($urandom, 1'b0, 1'b0, 1'b1));
    send_word(desc_word(make_l1(L1_PAGE, DOM_CLIENT, AP_FULL)));
    do_walk(make_req($urandom, 1'b0, 1'b0, 1'b1), make_l1(L1_SECTION, DOM_CLIENT, AP_ROM_SYS), '0);
    // descriptor with no walk open
    send_word(desc_word($urandom));
    settle();

    // Random phases, a new register setting each
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       configure(18'h0, 32'h0, SR_BOTH_CLEAR);
        1:       configure(18'h3ffff, 32'hffffffff, SR_SYSTEM);
        2:       configure(18'($urandom), 32'h55555555, SR_BOTH_SET);
        3:       configure(18'($urandom), $urandom, SR_ROM);
        4:       configure(18'($urandom), 32'h55555555, SR_BOTH_CLEAR);
        5:       configure(18'($urandom), $urandom, SR_SYSTEM);
        default: configure(18'($urandom), $urandom, 2'($urandom));
      endcase
      if (p == 2 || p == 5) stall_stretch_req = 1'b1;
      run_random(WORDS_PER_PHASE);
      settle();
    end

    walk_sb.report_leftovers();
    $display("covered %0d input words under %0d register settings", words_sent, PHASES + 1);
    $display("checked %0d descriptor reads, %0d translations, %0d aborts",
             walk_sb.read_count, walk_sb.done_count, walk_sb.fault_count);
    if (walk_sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
